### rtl/core/bb3_pkg.sv
`default_nettype none

package bb3_pkg;

   localparam int CHAN_W = 8;
   localparam int PIX_W = 3 * CHAN_W;
   localparam int LINE_W = 2 * PIX_W;
   localparam int SUM_W = 12;
   localparam int COL_W = 10;

   localparam int DIV9_MUL_W = 13;
   localparam int PROD_W = SUM_W + DIV9_MUL_W;
   localparam int DIV9_SHIFT = 16;
   localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = 13'd7282;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 13;
   localparam int WIDTH_FIELD_W = 12;
   localparam int HEIGHT_FIELD_W = 13;
   localparam int WIDTH_RESET = 640;
   localparam int HEIGHT_RESET = 480;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   typedef struct packed {
      logic              mode;
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red_out;
      logic [CHAN_W-1:0] green_out;
      logic [CHAN_W-1:0] blue_out;
      logic              last_of_frame;
   } rsp_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pix_type;

   typedef struct packed {
      logic [SUM_W-1:0] red;
      logic [SUM_W-1:0] green;
      logic [SUM_W-1:0] blue;
   } sums_type;

   typedef struct packed {
      logic restart;
      logic flush;
      logic col_zero;
      logic emit;
      logic mask_top;
      logic mask_bottom;
      logic mask_left;
      logic mask_right;
      logic last;
   } flags_type;

endpackage

`default_nettype wire

### rtl/core/box_blur_3x3_rgb.sv
// Channel  Dir  Handshake              Beat
// req      in   req_valid / req_stall  req_type: mode, red_in, green_in, blue_in
// rsp      out  rsp_valid / rsp_stall  rsp_type: red_out, green_out, blue_out, last_of_frame
// csr      in   csr_wr_en              csr_index, csr_data
//
// One beat is taken and one result delivered per clock unless its channel is stalled. A beat
// is registered in stage 1 with its line memory read, its window sums in stage 2 and its
// result in the output register; the line memory is written back when stage 1 advances, with
// a bypass when consecutive beats hit the same column. A frame's outputs trail its input by
// one line plus one pixel. Reset is synchronous; it empties the pipeline, clears the window
// and counters, and loads a 640 by 480 frame. The line memory needs no clearing pass. A
// stalled result holds in the output register while two more beats fill the pipeline.
`default_nettype none

module box_blur_3x3_rgb #(
   parameter int MAX_WIDTH = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  bb3_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output bb3_pkg::rsp_type                 rsp_data,
   input  logic                             csr_wr_en,
   input  logic [bb3_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bb3_pkg::CSR_DATA_W-1:0]   csr_data
);
   import bb3_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);

   logic              accept, drop, out_can, s2_free, s1_free, s1_adv, s2_adv;
   flags_type         flags;
   logic [AW-1:0]     addr;
   logic [LINE_W-1:0] line_rd, line_wr;
   pix_type           top_pix, mid_pix, new_pix;
   sums_type          sums;

   logic              s1_valid_ff, s1_valid_in;
   flags_type         s1_flags_ff, s1_flags_in;
   pix_type           s1_pix_ff, s1_pix_in;
   logic [AW-1:0]     s1_addr_ff, s1_addr_in;
   logic              s2_valid_ff, s2_valid_in;
   sums_type          s2_sums_ff, s2_sums_in;
   logic              s2_last_ff, s2_last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   function automatic logic [CHAN_W-1:0] div9(input logic [SUM_W-1:0] s);
      logic [PROD_W-1:0] p;
      p = PROD_W'(s) * PROD_W'(DIV9_MUL);
      return p[DIV9_SHIFT +: CHAN_W];
   endfunction

   bb3_ctrl #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_data (csr_data),
      .accept   (accept),
      .mode     (req_data.mode),
      .drop     (drop),
      .flags    (flags),
      .addr     (addr)
   );

   bb3_line #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_line (
      .clock  (clock),
      .rd_en  (accept && !drop),
      .rd_addr(addr),
      .wr_en  (s1_adv),
      .wr_addr(s1_addr_ff),
      .wr_data(line_wr),
      .rd_data(line_rd)
   );

   bb3_window u_window (
      .clock   (clock),
      .reset   (reset),
      .clear   (csr_wr_en),
      .shift_en(s1_adv),
      .flags   (s1_flags_ff),
      .top_pix (top_pix),
      .mid_pix (mid_pix),
      .new_pix (s1_pix_ff),
      .sums    (sums)
   );

   always_comb begin
      out_can = !rsp_valid_ff || !rsp_stall;
      s2_adv = s2_valid_ff && out_can;
      s2_free = !s2_valid_ff || out_can;
      s1_adv = s1_valid_ff && s2_free;
      s1_free = !s1_valid_ff || s2_free;
      req_stall = !s1_free;
      accept = req_valid && s1_free;

      top_pix = pix_type'(line_rd[LINE_W-1:PIX_W]);
      mid_pix = pix_type'(line_rd[PIX_W-1:0]);
      line_wr = {mid_pix, s1_pix_ff};

      new_pix.red = req_data.red_in;
      new_pix.green = req_data.green_in;
      new_pix.blue = req_data.blue_in;

      if (accept && !drop) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      s1_flags_in = accept ? flags : s1_flags_ff;
      s1_addr_in = accept ? addr : s1_addr_ff;
      if (accept) begin
         s1_pix_in = flags.flush ? '0 : new_pix;
      end else begin
         s1_pix_in = s1_pix_ff;
      end

      if (s1_adv) begin
         s2_valid_in = s1_flags_ff.emit;
      end else if (s2_adv) begin
         s2_valid_in = 1'b0;
      end else begin
         s2_valid_in = s2_valid_ff;
      end
      s2_sums_in = s1_adv ? sums : s2_sums_ff;
      s2_last_in = s1_adv ? s1_flags_ff.last : s2_last_ff;

      rsp_valid_in = out_can ? s2_valid_ff : rsp_valid_ff;
      if (s2_adv) begin
         rsp_data_in.red_out = div9(s2_sums_ff.red);
         rsp_data_in.green_out = div9(s2_sums_ff.green);
         rsp_data_in.blue_out = div9(s2_sums_ff.blue);
         rsp_data_in.last_of_frame = s2_last_ff;
      end else begin
         rsp_data_in = rsp_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_flags_ff <= s1_flags_in;
      s1_addr_ff <= s1_addr_in;
      s1_pix_ff <= s1_pix_in;
      s2_sums_ff <= s2_sums_in;
      s2_last_ff <= s2_last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

`default_nettype wire

### rtl/core/bb3_ctrl.sv
`default_nettype none

module bb3_ctrl #(
   parameter int MAX_WIDTH = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [bb3_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bb3_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic                             accept,
   input  logic                             mode,
   output logic                             drop,
   output bb3_pkg::flags_type               flags,
   output logic [$clog2(MAX_WIDTH)-1:0]     addr
);
   import bb3_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int RW = $clog2(MAX_HEIGHT + 3);
   localparam int AW = $clog2(MAX_WIDTH);
   localparam logic [CW-1:0] WIDTH_AT_RESET =
      CW'((WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET);
   localparam logic [RW-1:0] HEIGHT_AT_RESET =
      RW'((HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET);

   logic [CW-1:0] width_ff, width_in;
   logic [RW-1:0] height_ff, height_in;
   logic [CW-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [RW-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in;

   logic                      done, pending, restart;
   logic [CW-1:0]             icol, ocol, icol_step, ocol_step;
   logic [RW-1:0]             irow, orow;
   logic [WIDTH_FIELD_W-1:0]  wv;
   logic [HEIGHT_FIELD_W-1:0] hv;
   logic [CW-1:0]             w_clamp;
   logic [RW-1:0]             h_clamp;

   always_comb begin
      done = out_row_ff >= height_ff;
      pending = in_row_ff >= height_ff;
      restart = done && !mode;
      drop = mode && (done || !pending);

      icol = restart ? '0 : in_col_ff;
      irow = restart ? '0 : in_row_ff;
      ocol = restart ? '0 : out_col_ff;
      orow = restart ? '0 : out_row_ff;

      flags.restart = restart;
      flags.flush = !done && pending;
      flags.col_zero = icol == '0;
      flags.emit = (irow >= RW'(2)) || ((irow == RW'(1)) && (icol != '0));
      flags.mask_top = orow == '0;
      flags.mask_bottom = orow == (height_ff - RW'(1));
      flags.mask_left = ocol == '0;
      flags.mask_right = ocol == (width_ff - CW'(1));
      flags.last = flags.mask_bottom && flags.mask_right;
      addr = icol[AW-1:0];

      icol_step = icol + CW'(1);
      ocol_step = ocol + CW'(1);

      wv = csr_data[WIDTH_FIELD_W-1:0];
      hv = csr_data[HEIGHT_FIELD_W-1:0];
      if (wv == '0) begin
         w_clamp = CW'(1);
      end else if (32'(wv) > 32'(MAX_WIDTH)) begin
         w_clamp = CW'(MAX_WIDTH);
      end else begin
         w_clamp = CW'(wv);
      end
      if (hv == '0) begin
         h_clamp = RW'(1);
      end else if (32'(hv) > 32'(MAX_HEIGHT)) begin
         h_clamp = RW'(MAX_HEIGHT);
      end else begin
         h_clamp = RW'(hv);
      end

      width_in = width_ff;
      height_in = height_ff;
      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: begin
               width_in = w_clamp;
            end
            CSR_IMAGE_HEIGHT: begin
               height_in = h_clamp;
            end
            default: begin
            end
         endcase
         in_col_in = '0;
         in_row_in = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (accept && !drop) begin
         if (icol_step >= width_ff) begin
            in_col_in = '0;
            in_row_in = irow + RW'(1);
         end else begin
            in_col_in = icol_step;
            in_row_in = irow;
         end
         if (flags.emit) begin
            if (ocol_step >= width_ff) begin
               out_col_in = '0;
               out_row_in = orow + RW'(1);
            end else begin
               out_col_in = ocol_step;
               out_row_in = orow;
            end
         end else begin
            out_col_in = ocol;
            out_row_in = orow;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_AT_RESET;
         height_ff <= HEIGHT_AT_RESET;
         in_col_ff <= '0;
         in_row_ff <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         width_ff <= width_in;
         height_ff <= height_in;
         in_col_ff <= in_col_in;
         in_row_ff <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/bb3_line.sv
`default_nettype none

module bb3_line #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
   input  logic                          wr_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]  wr_addr,
   input  logic [bb3_pkg::LINE_W-1:0]    wr_data,
   output logic [bb3_pkg::LINE_W-1:0]    rd_data
);
   import bb3_pkg::*;

   logic [LINE_W-1:0] mem_ff [0:MAX_WIDTH-1];
   logic [LINE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/core/bb3_window.sv
`default_nettype none

module bb3_window (
   input  logic                clock,
   input  logic                reset,
   input  logic                clear,
   input  logic                shift_en,
   input  bb3_pkg::flags_type  flags,
   input  bb3_pkg::pix_type    top_pix,
   input  bb3_pkg::pix_type    mid_pix,
   input  bb3_pkg::pix_type    new_pix,
   output bb3_pkg::sums_type   sums
);
   import bb3_pkg::*;

   pix_type          win_ff [0:8];
   pix_type          win_in [0:8];
   pix_type          base [0:8];
   pix_type          shifted [0:8];
   pix_type          cols [0:8];
   pix_type          taps [0:8];
   logic [COL_W-1:0] col_red [0:2];
   logic [COL_W-1:0] col_green [0:2];
   logic [COL_W-1:0] col_blue [0:2];
   logic             keep;

   always_comb begin
      keep = 1'b0;
      for (int i = 0; i < 9; i++) begin
         base[i] = flags.restart ? '0 : win_ff[i];
      end
      for (int i = 0; i < 6; i++) begin
         shifted[i] = base[i + 3];
      end
      shifted[6] = top_pix;
      shifted[7] = mid_pix;
      shifted[8] = new_pix;

      for (int i = 0; i < 6; i++) begin
         cols[i] = flags.col_zero ? base[i + 3] : shifted[i];
      end
      for (int i = 6; i < 9; i++) begin
         cols[i] = flags.col_zero ? '0 : shifted[i];
      end

      for (int k = 0; k < 3; k++) begin
         for (int r = 0; r < 3; r++) begin
            keep = !((k == 0) && flags.mask_left) && !((k == 2) && flags.mask_right) &&
                   !((r == 0) && flags.mask_top) && !((r == 2) && flags.mask_bottom);
            taps[k * 3 + r] = keep ? cols[k * 3 + r] : '0;
         end
      end

      for (int k = 0; k < 3; k++) begin
         col_red[k] = COL_W'(taps[k * 3].red) + COL_W'(taps[k * 3 + 1].red) +
                      COL_W'(taps[k * 3 + 2].red);
         col_green[k] = COL_W'(taps[k * 3].green) + COL_W'(taps[k * 3 + 1].green) +
                        COL_W'(taps[k * 3 + 2].green);
         col_blue[k] = COL_W'(taps[k * 3].blue) + COL_W'(taps[k * 3 + 1].blue) +
                       COL_W'(taps[k * 3 + 2].blue);
      end
      sums.red = SUM_W'(col_red[0]) + SUM_W'(col_red[1]) + SUM_W'(col_red[2]);
      sums.green = SUM_W'(col_green[0]) + SUM_W'(col_green[1]) + SUM_W'(col_green[2]);
      sums.blue = SUM_W'(col_blue[0]) + SUM_W'(col_blue[1]) + SUM_W'(col_blue[2]);

      for (int i = 0; i < 9; i++) begin
         win_in[i] = shift_en ? shifted[i] : win_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

endmodule

`default_nettype wire

### rtl/core/bb3_checker.sv
`default_nettype none

module bb3_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input bb3_pkg::rsp_type  rsp_data
);
   import bb3_pkg::*;

   logic req_beat;

   assign req_beat = req_valid && !req_stall;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   assert property (@(posedge clock) req_stall |-> rsp_valid && rsp_stall)
      else $error("req_stall raised without a stalled result");

   assert property (@(posedge clock) disable iff (reset)
      (!req_beat && !rsp_stall) ##1 (!req_beat && !rsp_stall) ##1
      (!req_beat && !rsp_stall) |=> !rsp_valid)
      else $error("pipeline did not drain");

endmodule

bind box_blur_3x3_rgb bb3_checker u_bb3_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);

`default_nettype wire
